// File: hw/rtl/bcb_pkg.sv
// shared types, constants and helpers of the block comment blanker
package bcb_pkg;

  localparam int MAX_MARKER = 4;
  // markers are packed into 32 bits, so no more than four characters are ever compared
  localparam int WIN_DEPTH  = (MAX_MARKER < 4) ? MAX_MARKER : 4;
  localparam int CNT_W      = $clog2(WIN_DEPTH + 1);
  localparam int LEN_W      = 3;
  localparam int IDX_W      = 3;
  localparam int DATA_W     = 32;

  localparam logic [31:0]      OPEN_MARKER_RST  = 32'd10799;
  localparam logic [LEN_W-1:0] OPEN_LENGTH_RST  = 3'd2;
  localparam logic [31:0]      CLOSE_MARKER_RST = 32'd12074;
  localparam logic [LEN_W-1:0] CLOSE_LENGTH_RST = 3'd2;
  localparam logic [7:0]       FILL_BYTE_RST    = 8'd32;

  typedef enum logic [IDX_W-1:0] {
    CFG_OPEN_MARKER  = 3'd0,
    CFG_OPEN_LENGTH  = 3'd1,
    CFG_CLOSE_MARKER = 3'd2,
    CFG_CLOSE_LENGTH = 3'd3,
    CFG_FILL_BYTE    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  typedef struct packed {
    logic [31:0]      open_marker;
    logic [LEN_W-1:0] open_length;
    logic [31:0]      close_marker;
    logic [LEN_W-1:0] close_length;
    logic [7:0]       fill_byte;
  } cfg_t;

  // clamp a length register into 1..WIN_DEPTH
  function automatic logic [CNT_W-1:0] eff_len(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] n;
    n = v;
    if (n == '0) n = LEN_W'(1);
    if (n > LEN_W'(WIN_DEPTH)) n = LEN_W'(WIN_DEPTH);
    return CNT_W'(n);
  endfunction

endpackage

// File: hw/rtl/bcb_front.sv
// front end: accepts text items into a two-entry queue ahead of the scanner
module bcb_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  bcb_pkg::in_item_t text_i,
  output logic              valid_o,
  output bcb_pkg::in_item_t head_o,
  input  logic              take_i
);
  import bcb_pkg::*;

  in_item_t   mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full    = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push && !full;
  assign do_pop  = take_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= text_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// File: hw/rtl/bcb_outq.sv
// result queue: two entries between the scanner and the consumer
module bcb_outq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bcb_pkg::out_item_t item_i,
  output logic               space_o,
  output logic               empty,
  input  logic               pop,
  output bcb_pkg::out_item_t result_o
);
  import bcb_pkg::*;

  out_item_t  mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign space_o  = (cnt_q != 2'd2);
  assign empty    = (cnt_q == 2'd0);
  assign result_o = mem_q[rd_q];
  assign do_push  = push_i && space_o;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// File: hw/rtl/bcb_back.sv
// back end: lookahead window, marker matching and blanking, one result per cycle while the result queue has space
module bcb_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bcb_pkg::cfg_t      cfg_i,
  input  logic               in_valid_i,
  input  bcb_pkg::in_item_t  in_item_i,
  output logic               in_take_o,
  input  logic               out_space_i,
  output logic               out_push_o,
  output bcb_pkg::out_item_t out_item_o
);
  import bcb_pkg::*;

  logic [7:0]       win_q [WIN_DEPTH];
  logic [7:0]       win_d [WIN_DEPTH];
  logic [7:0]       cand  [WIN_DEPTH];
  logic [CNT_W-1:0] cnt_q, cnt_d, cand_cnt;
  logic             inside_q, inside_d;
  logic [CNT_W-1:0] crem_q, crem_d;
  logic             flush_q, flush_d, cand_flush;
  logic             drain_q, drain_d, cand_drain;

  logic [CNT_W-1:0] ol, cl, need;
  logic             open_hit, close_hit, ins1, emit, emit_last;

  assign ol   = eff_len(cfg_i.open_length);
  assign cl   = eff_len(cfg_i.close_length);
  assign need = (ol > cl) ? ol : cl;

  // a new byte joins only while no flush or drain is pending and the window has room
  assign in_take_o = in_valid_i && !flush_q && !drain_q && (cnt_q < CNT_W'(WIN_DEPTH));

  always_comb begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      cand[i] = (in_take_o && (CNT_W'(i) == cnt_q)) ? in_item_i.text_byte : win_q[i];
    end
    cand_cnt   = cnt_q + CNT_W'(in_take_o);
    cand_flush = flush_q || (in_take_o && in_item_i.text_last);
    // bytes leave in answer to a taken item, and a pending drain carries on without a new one
    cand_drain = drain_q || (in_take_o && !in_item_i.text_last);
  end

  // marker compares at the head of the window
  always_comb begin
    open_hit  = (ol <= cand_cnt);
    close_hit = (cl <= cand_cnt);
    for (int i = 0; i < WIN_DEPTH; i++) begin
      if ((CNT_W'(i) < ol) && (cand[i] != cfg_i.open_marker[8*i +: 8])) open_hit = 1'b0;
      if ((CNT_W'(i) < cl) && (cand[i] != cfg_i.close_marker[8*i +: 8])) close_hit = 1'b0;
    end
  end

  assign emit       = (cand_cnt != '0) && (cand_flush || (cand_drain && (cand_cnt >= need)))
                      && out_space_i;
  assign emit_last  = emit && cand_flush && (cand_cnt == CNT_W'(1));
  assign out_push_o = emit;

  always_comb begin
    inside_d            = inside_q;
    crem_d              = crem_q;
    ins1                = inside_q || open_hit;
    out_item_o.out_byte = cand[0];
    out_item_o.out_last = emit_last;
    if (crem_q != '0) begin
      out_item_o.out_byte = cfg_i.fill_byte;
      crem_d              = crem_q - CNT_W'(1);
    end else if (ins1) begin
      out_item_o.out_byte = cfg_i.fill_byte;
      if (close_hit) begin
        inside_d = 1'b0;
        crem_d   = cl - CNT_W'(1);
      end else begin
        inside_d = 1'b1;
      end
    end

    for (int i = 0; i < WIN_DEPTH; i++) win_d[i] = cand[i];
    cnt_d   = cand_cnt;
    flush_d = cand_flush;
    if (emit) begin
      for (int i = 0; i < WIN_DEPTH - 1; i++) win_d[i] = cand[i+1];
      cnt_d = cand_cnt - CNT_W'(1);
    end else begin
      inside_d = inside_q;
      crem_d   = crem_q;
    end
    drain_d = cand_drain && (cnt_d >= need);
    // end of text returns the scanner to its idle state
    if (emit_last) begin
      inside_d = 1'b0;
      crem_d   = '0;
      flush_d  = 1'b0;
      drain_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < WIN_DEPTH; i++) win_q[i] <= win_d[i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      inside_q <= 1'b0;
      crem_q   <= '0;
      flush_q  <= 1'b0;
      drain_q  <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      inside_q <= inside_d;
      crem_q   <= crem_d;
      flush_q  <= flush_d;
      drain_q  <= drain_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(WIN_DEPTH))
    else $error("window count above depth");

  a_crem_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (crem_q != '0) |-> !inside_q)
    else $error("closing marker tail while still inside comment");

  a_flush_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_q |-> (cnt_q != '0))
    else $error("flush pending with empty window");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_last |=> (cnt_q == '0) && !flush_q && !inside_q && (crem_q == '0))
    else $error("state not cleared after final item");

endmodule

// File: hw/rtl/block_comment_blanker_core.sv
// top level: configuration registers, front queue, scanner and result queue
// path: a pushed byte is registered in the front queue, passes the scanner and is registered
//   in the result queue, once the lookahead window holds the longer marker's length of bytes (or the last item came)
// throughput: one item per cycle while the result queue has space; a last item drains the window,
//   one result per cycle for each byte it holds (up to four), and meanwhile no new byte enters the scanner
// reset: asynchronous, active low; queues and scanner state clear, registers take defaults
module block_comment_blanker_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  bcb_pkg::in_item_t             text_i,
  output logic                          empty,
  input  logic                          pop,
  output bcb_pkg::out_item_t            result_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bcb_pkg::IDX_W-1:0]     cfg_index_i,
  input  logic [bcb_pkg::DATA_W-1:0]    cfg_data_i
);
  import bcb_pkg::*;

  cfg_t      cfg_q;
  logic      q_valid, q_take, out_space, out_push;
  in_item_t  q_head;
  out_item_t out_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.open_marker  <= OPEN_MARKER_RST;
      cfg_q.open_length  <= OPEN_LENGTH_RST;
      cfg_q.close_marker <= CLOSE_MARKER_RST;
      cfg_q.close_length <= CLOSE_LENGTH_RST;
      cfg_q.fill_byte    <= FILL_BYTE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_OPEN_MARKER:  cfg_q.open_marker  <= cfg_data_i[31:0];
        CFG_OPEN_LENGTH:  cfg_q.open_length  <= cfg_data_i[LEN_W-1:0];
        CFG_CLOSE_MARKER: cfg_q.close_marker <= cfg_data_i[31:0];
        CFG_CLOSE_LENGTH: cfg_q.close_length <= cfg_data_i[LEN_W-1:0];
        CFG_FILL_BYTE:    cfg_q.fill_byte    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  bcb_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .text_i  (text_i),
    .valid_o (q_valid),
    .head_o  (q_head),
    .take_i  (q_take)
  );

  bcb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (q_valid),
    .in_item_i   (q_head),
    .in_take_o   (q_take),
    .out_space_i (out_space),
    .out_push_o  (out_push),
    .out_item_o  (out_item)
  );

  bcb_outq u_outq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (out_push),
    .item_i   (out_item),
    .space_o  (out_space),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o)
  );

endmodule

// File: tb/block_comment_blanker_core_test.sv
// testbench for the block comment blanker core: directed and random texts checked byte by byte
`timescale 1ns / 100ps

module block_comment_blanker_core_test;
  import bcb_pkg::*;

  localparam int DRAIN_WAIT = 16;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              push        = 1'b0;
  logic              full;
  in_item_t          text_i      = '0;
  logic              empty;
  logic              pop         = 1'b0;
  out_item_t         result_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [IDX_W-1:0]  cfg_index_i = '0;
  logic [DATA_W-1:0] cfg_data_i  = '0;

  block_comment_blanker_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .text_i      (text_i),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // predictor copy of the registers and the scanner state
  logic [31:0]      open_mk   = OPEN_MARKER_RST;
  logic [LEN_W-1:0] open_len  = OPEN_LENGTH_RST;
  logic [31:0]      close_mk  = CLOSE_MARKER_RST;
  logic [LEN_W-1:0] close_len = CLOSE_LENGTH_RST;
  logic [7:0]       fill      = FILL_BYTE_RST;

  logic [7:0] win [WIN_DEPTH];
  int         win_cnt    = 0;
  bit         in_comment = 1'b0;
  int         close_left = 0;

  out_item_t blanked_q [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches    = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("timeout");
    $display("Test completed with failures");
    $finish;
  end

  function automatic int clamp_length(logic [LEN_W-1:0] v);
    int n;
    n = v;
    if (n < 1) n = 1;
    if (n > WIN_DEPTH) n = WIN_DEPTH;
    return n;
  endfunction

  function automatic bit marker_at_front(logic [31:0] mk, int len);
    if (len > win_cnt) return 1'b0;
    for (int i = 0; i < len; i++) begin
      if (win[i] != mk[8*i +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void emit_front(bit final_one);
    out_item_t r;
    int        cl;
    if (close_left > 0) begin
      r.out_byte = fill;
      close_left--;
    end else begin
      if (!in_comment && marker_at_front(open_mk, clamp_length(open_len))) in_comment = 1'b1;
      if (in_comment) begin
        cl = clamp_length(close_len);
        // closing search starts at the very byte that opened the comment
        if (marker_at_front(close_mk, cl)) begin
          in_comment = 1'b0;
          close_left = cl - 1;
        end
        r.out_byte = fill;
      end else begin
        r.out_byte = win[0];
      end
    end
    r.out_last = final_one;
    blanked_q.push_back(r);
    for (int i = 1; i < win_cnt; i++) win[i-1] = win[i];
    if (win_cnt > 0) win_cnt--;
  endfunction

  function automatic void predict_blanking(logic [7:0] b, bit last);
    int need;
    need = clamp_length(open_len);
    if (clamp_length(close_len) > need) need = clamp_length(close_len);
    if (win_cnt < WIN_DEPTH) begin
      win[win_cnt] = b;
      win_cnt++;
    end
    if (last) begin
      // end of text flushes the whole window and starts afresh
      while (win_cnt > 0) emit_front(win_cnt == 1);
      for (int i = 0; i < WIN_DEPTH; i++) win[i] = '0;
      in_comment = 1'b0;
      close_left = 0;
    end else begin
      while (win_cnt >= need && win_cnt > 0) emit_front(1'b0);
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && pop && !empty) begin
      if (blanked_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: byte %h last %b", result_o.out_byte, result_o.out_last);
      end else begin
        want = blanked_q.pop_front();
        if (result_o.out_byte !== want.out_byte || result_o.out_last !== want.out_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected byte %h last %b, got byte %h last %b",
                     want.out_byte, want.out_last, result_o.out_byte, result_o.out_last);
        end
      end
    end
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_char(logic [7:0] b, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push             <= 1'b1;
    text_i.text_byte <= b;
    text_i.text_last <= last;
    do @(posedge clk_i); while (full);
    predict_blanking(b, last);
  endtask

  task automatic send_string(string s, bit last_at_end);
    for (int i = 0; i < s.len(); i++) send_char(s[i], last_at_end && (i == s.len() - 1));
  endtask

  // let every expected item out, then give the pipeline time to settle
  task automatic wait_drained();
    push <= 1'b0;
    while (blanked_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_OPEN_MARKER:  open_mk   = data;
      CFG_OPEN_LENGTH:  open_len  = data[LEN_W-1:0];
      CFG_CLOSE_MARKER: close_mk  = data;
      CFG_CLOSE_LENGTH: close_len = data[LEN_W-1:0];
      CFG_FILL_BYTE:    fill      = data[7:0];
      default: ;
    endcase
  endtask

  task automatic load_config(logic [31:0] om, logic [2:0] ol, logic [31:0] cm,
                             logic [2:0] cl, logic [7:0] fb);
    write_reg(CFG_OPEN_MARKER, om);
    write_reg(CFG_OPEN_LENGTH, 32'(ol));
    write_reg(CFG_CLOSE_MARKER, cm);
    write_reg(CFG_CLOSE_LENGTH, 32'(cl));
    write_reg(CFG_FILL_BYTE, 32'(fb));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_default_markers();
    // markers overlapping on the middle star, then an unclosed comment, then a cut marker
    send_string("/*/", 1'b0);
    send_char("x", 1'b1);
    send_char(8'hFF, 1'b0);
    send_string("/*", 1'b0);
    send_char(8'h01, 1'b1);
    send_string("a/", 1'b1);
    wait_drained();
  endtask

  task automatic test_clamped_lengths();
    // open length 0 acts as 1, close length 7 acts as 4
    load_config(32'h0000_005A, 3'd0, 32'hFFFF_FFFF, 3'd7, 8'h00);
    send_char("Z", 1'b0);
    repeat (4) send_char(8'hFF, 1'b0);
    send_char("a", 1'b1);
    wait_drained();
  endtask

  task automatic test_length_change_mid_text();
    // zero in the first marker byte, so the comment never opens on nonzero text
    load_config(32'h0000_2F00, 3'd2, CLOSE_MARKER_RST, 3'd4, 8'hFF);
    send_string("/ab", 1'b0);
    wait_drained();
    load_config(32'h0000_2F00, 3'd2, 32'h0000_002A, 3'd1, 8'hFF);
    send_char("c", 1'b0);
    send_char("d", 1'b1);
    wait_drained();
  endtask

  function automatic logic [7:0] nonzero(logic [7:0] b);
    return (b == 8'h00) ? 8'($urandom_range(255, 1)) : b;
  endfunction

  function automatic logic [31:0] random_marker();
    logic [31:0] mk;
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(9))
        0:       mk[8*i +: 8] = 8'h00;
        1:       mk[8*i +: 8] = 8'hFF;
        2:       mk[8*i +: 8] = 8'h01;
        default: mk[8*i +: 8] = 8'($urandom_range(255, 1));
      endcase
    end
    return mk;
  endfunction

  task automatic test_random_texts(int sp, int rp);
    logic [7:0] txt [$];
    logic [7:0] fb;
    int         sent;
    int         goal;
    bit         open_end;
    send_idle_pct = sp;
    recv_idle_pct = rp;
    for (int setting = 0; setting < 4; setting++) begin
      wait_drained();
      case ($urandom_range(3))
        0:       fb = 8'h00;
        1:       fb = 8'hFF;
        default: fb = 8'($urandom_range(255));
      endcase
      load_config(random_marker(), 3'($urandom_range(7)), random_marker(),
                  3'($urandom_range(7)), fb);
      sent = 0;
      while (sent < 17) begin
        txt.delete();
        goal = ($urandom_range(7) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 1);
        // mostly marker material so that comments open and close often
        while (txt.size() < goal) begin
          case ($urandom_range(9))
            0, 1, 2: for (int i = 0; i < clamp_length(open_len); i++)
                       txt.push_back(nonzero(open_mk[8*i +: 8]));
            3, 4:    for (int i = 0; i < clamp_length(close_len); i++)
                       txt.push_back(nonzero(close_mk[8*i +: 8]));
            5, 6, 7: txt.push_back(nonzero($urandom_range(1) ? open_mk[8*$urandom_range(3) +: 8]
                                                             : close_mk[8*$urandom_range(3) +: 8]));
            default: txt.push_back(8'($urandom_range(255, 1)));
          endcase
        end
        open_end = ($urandom_range(5) == 0);
        foreach (txt[i]) send_char(txt[i], !open_end && (i == txt.size() - 1));
        sent += txt.size();
      end
    end
  endtask

  initial begin
    for (int i = 0; i < WIN_DEPTH; i++) win[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 37;
    recv_idle_pct = 84;
    test_default_markers();
    test_clamped_lengths();
    test_length_change_mid_text();

    test_random_texts(37, 84);
    test_random_texts(84, 37);
    test_random_texts(0, 0);
    send_char("e", 1'b1);
    wait_drained();

    if (blanked_q.size() != 0) begin
      mismatches++;
      $display("items never received: %0d", blanked_q.size());
    end
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
